// ===== design/toeq_pkg.sv =====
// Shared types and constants for the time-ordered event queue.
// Holds the channel payload structs, the stored slot layout and the sequencer states.
// No dependencies.
package toeq_pkg;

  localparam int unsigned TYPE_W = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned OCC_W  = 7;

  // Command codes carried in the cmd field.
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_POP = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [TYPE_W-1:0] new_type;
    logic [TIME_W-1:0] new_time;
    logic [TAG_W-1:0]  new_subject;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [TYPE_W-1:0] out_type;
    logic [TIME_W-1:0] out_time;
    logic [TAG_W-1:0]  out_subject;
    logic              dropped;
    logic [OCC_W-1:0]  occupancy;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] slot_time;
    logic [TYPE_W-1:0] slot_type;
    logic [TAG_W-1:0]  slot_subject;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD_CMP,
    ST_MID_RD,
    ST_MID_CMP,
    ST_SHIFT,
    ST_WRITE_NEW,
    ST_POP_TAKE,
    ST_RESULT
  } state_e;

endpackage

// ===== design/toeq_slot_ram.sv =====
// Slot storage for the event queue: one write port and one registered read port.
// Depends on toeq_pkg for the slot layout.
module toeq_slot_ram #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(DEPTH)-1:0]     waddr_i,
  input  toeq_pkg::slot_t              wdata_i,
  input  logic [$clog2(DEPTH)-1:0]     raddr_i,
  output toeq_pkg::slot_t              rdata_o
);

  toeq_pkg::slot_t mem_q [DEPTH];
  toeq_pkg::slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/time_ordered_event_queue_unit.sv =====
// Top level of the time-ordered event queue: sequencer, bisection search and slot shifter.
// Depends on toeq_pkg and toeq_slot_ram.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------
//   in      | input     | in_valid_i / in_ready_o    | in_item_i  (in_item_t)
//   out     | output    | out_valid_o / out_ready_i  | out_item_o (out_item_t)
//
// One slot memory port sets the timing. An add checks the head and, unless it goes ahead
// of it, bisects with at most ceil(log2 n) probes over n events; it then shifts the later
// events up and writes itself; a pop takes the head, and a drop or empty pop just reports.
// Reset clears the occupancy count and the sequencer; slot contents are not cleared.
// in_ready_o is high only while the sequencer is idle; a finished result waits in the
// output register, so the next item can be accepted while it is stalled.
module time_ordered_event_queue_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  toeq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output toeq_pkg::out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  toeq_pkg::state_e    state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  toeq_pkg::in_item_t  item_q, item_d;
  logic [CW-1:0]       pos_q, pos_d;
  logic [CW-1:0]       lo_q, lo_d;
  logic [CW-1:0]       hi_q, hi_d;
  logic [AW-1:0]       mid_q, mid_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic [CW-1:0]       rem_q, rem_d;
  logic                dir_up_q, dir_up_d;
  logic                rd_pend_q, rd_pend_d;
  logic [AW-1:0]       wa_q, wa_d;
  toeq_pkg::out_item_t res_q, res_d;
  toeq_pkg::out_item_t out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  toeq_pkg::slot_t     ram_wdata;
  logic [AW-1:0]       ram_raddr;
  toeq_pkg::slot_t     ram_rdata;

  logic [CW:0]         mid_sum;
  logic [CW-1:0]       mid_full;
  logic                in_xfer;

  toeq_slot_ram #(
    .DEPTH(CAPACITY)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o  = (state_q == toeq_pkg::ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Midpoint of the current search window.
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_full = mid_sum[CW:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= toeq_pkg::ST_IDLE;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    pos_q    <= pos_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    ptr_q    <= ptr_d;
    rem_q    <= rem_d;
    dir_up_q <= dir_up_d;
    wa_q     <= wa_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    item_d      = item_q;
    pos_d       = pos_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    ptr_d       = ptr_q;
    rem_d       = rem_q;
    dir_up_d    = dir_up_q;
    rd_pend_d   = 1'b0;
    wa_d        = wa_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    ram_we      = 1'b0;
    ram_waddr   = wa_q;
    ram_wdata   = ram_rdata;
    // While idle the head slot is read, so its data is ready right after a transfer.
    ram_raddr   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      toeq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          item_d = in_item_i;
          res_d  = '0;
          if (in_item_i.cmd == toeq_pkg::CMD_POP) begin
            if (cnt_q == '0) begin
              state_d = toeq_pkg::ST_RESULT;
            end else begin
              state_d = toeq_pkg::ST_POP_TAKE;
            end
          end else if (cnt_q == CW'(CAPACITY)) begin
            res_d.dropped = 1'b1;
            state_d       = toeq_pkg::ST_RESULT;
          end else if (cnt_q == '0) begin
            pos_d   = '0;
            state_d = toeq_pkg::ST_WRITE_NEW;
          end else begin
            state_d = toeq_pkg::ST_HEAD_CMP;
          end
        end
      end

      toeq_pkg::ST_HEAD_CMP: begin
        // A strictly later head means the new event becomes the new head.
        if (ram_rdata.slot_time > item_q.new_time) begin
          pos_d    = '0;
          rem_d    = cnt_q;
          ptr_d    = AW'(cnt_q - CW'(1));
          dir_up_d = 1'b0;
          state_d  = toeq_pkg::ST_SHIFT;
        end else begin
          lo_d    = '0;
          hi_d    = cnt_q;
          state_d = toeq_pkg::ST_MID_RD;
        end
      end

      toeq_pkg::ST_MID_RD: begin
        if ((hi_q - lo_q) > CW'(1)) begin
          mid_d     = mid_full[AW-1:0];
          ram_raddr = mid_full[AW-1:0];
          state_d   = toeq_pkg::ST_MID_CMP;
        end else begin
          // Window has closed: the insert point is its upper end.
          pos_d    = hi_q;
          rem_d    = cnt_q - hi_q;
          ptr_d    = AW'(cnt_q - CW'(1));
          dir_up_d = 1'b0;
          state_d  = toeq_pkg::ST_SHIFT;
        end
      end

      toeq_pkg::ST_MID_CMP: begin
        if (ram_rdata.slot_time < item_q.new_time) begin
          lo_d = CW'(mid_q);
        end else begin
          hi_d = CW'(mid_q);
        end
        state_d = toeq_pkg::ST_MID_RD;
      end

      toeq_pkg::ST_SHIFT: begin
        // Each slot read in one cycle is written one place over in the next.
        if (rd_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wa_q;
          ram_wdata = ram_rdata;
        end
        if (rem_q != '0) begin
          ram_raddr = ptr_q;
          rd_pend_d = 1'b1;
          wa_d      = dir_up_q ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
          ptr_d     = dir_up_q ? (ptr_q + AW'(1)) : (ptr_q - AW'(1));
          rem_d     = rem_q - CW'(1);
        end else if (!rd_pend_q) begin
          state_d = dir_up_q ? toeq_pkg::ST_RESULT : toeq_pkg::ST_WRITE_NEW;
        end
      end

      toeq_pkg::ST_WRITE_NEW: begin
        ram_we                 = 1'b1;
        ram_waddr              = pos_q[AW-1:0];
        ram_wdata.slot_time    = item_q.new_time;
        ram_wdata.slot_type    = item_q.new_type;
        ram_wdata.slot_subject = item_q.new_subject;
        cnt_d                  = cnt_q + CW'(1);
        state_d                = toeq_pkg::ST_RESULT;
      end

      toeq_pkg::ST_POP_TAKE: begin
        res_d.found       = 1'b1;
        res_d.out_type    = ram_rdata.slot_type;
        res_d.out_time    = ram_rdata.slot_time;
        res_d.out_subject = ram_rdata.slot_subject;
        // Move the remaining events one place toward the head.
        ptr_d             = AW'(1);
        rem_d             = cnt_q - CW'(1);
        dir_up_d          = 1'b1;
        cnt_d             = cnt_q - CW'(1);
        state_d           = toeq_pkg::ST_SHIFT;
      end

      toeq_pkg::ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d           = res_q;
          out_d.occupancy = toeq_pkg::OCC_W'(cnt_q);
          out_valid_d     = 1'b1;
          state_d         = toeq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = toeq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/toeq_checker.sv =====
// Port-level checks for the time-ordered event queue, attached by a bind statement.
// Depends on toeq_pkg and on the port names of time_ordered_event_queue_unit.
module toeq_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input toeq_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input toeq_pkg::out_item_t out_item_o
);

  // An accepted item keeps the block busy for at least the next cycle.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on two consecutive cycles");

  // A result never both returns an event and reports a drop.
  a_found_drop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.found && out_item_o.dropped))
    else $error("result is both found and dropped");

  // Without a returned event the event fields read as zero.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.found |->
      (out_item_o.out_type == '0) && (out_item_o.out_time == '0) &&
      (out_item_o.out_subject == '0))
    else $error("event fields not zero without a returned event");

  // A dropped add is only reported when the queue is full.
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.dropped |->
      (out_item_o.occupancy == toeq_pkg::OCC_W'(CAPACITY)))
    else $error("drop reported while the queue has room");

  // A stalled result holds its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

endmodule

bind time_ordered_event_queue_unit toeq_checker #(
  .CAPACITY(CAPACITY)
) u_toeq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);

// ===== dv/toeq_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the time-ordered event queue. It watches both channels and keeps a sorted copy
// of the stored events. It compares every result, field by field, with the oldest expectation.
// Depends on toeq_pkg.
module toeq_scoreboard #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  toeq_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  toeq_pkg::out_item_t out_item_i,
  output int                  mismatch_count_o,
  output int                  pending_count_o,
  output int                  result_count_o,
  output int                  drop_count_o,
  output int                  empty_pop_count_o,
  output int                  peak_occupancy_o
);

  toeq_pkg::slot_t     stored_events[$];
  toeq_pkg::out_item_t pending_results[$];

  int mismatches  = 0;
  int waiting     = 0;
  int results     = 0;
  int drops       = 0;
  int empty_pops  = 0;
  int peak_fill   = 0;

  assign mismatch_count_o  = mismatches;
  assign pending_count_o   = waiting;
  assign result_count_o    = results;
  assign drop_count_o      = drops;
  assign empty_pop_count_o = empty_pops;
  assign peak_occupancy_o  = peak_fill;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Applies one command to the local copy of the queue and returns the result it should give.
  function automatic toeq_pkg::out_item_t apply_command(input toeq_pkg::in_item_t item);
    toeq_pkg::out_item_t res;
    toeq_pkg::slot_t     evt;
    int                  pos;
    res = '0;
    if (item.cmd == toeq_pkg::CMD_POP) begin
      if (stored_events.size() > 0) begin
        evt             = stored_events.pop_front();
        res.found       = 1'b1;
        res.out_type    = evt.slot_type;
        res.out_time    = evt.slot_time;
        res.out_subject = evt.slot_subject;
      end else begin
        empty_pops++;
      end
    end else if (stored_events.size() >= QUEUE_DEPTH) begin
      res.dropped = 1'b1;
      drops++;
    end else begin
      evt.slot_time    = item.new_time;
      evt.slot_type    = item.new_type;
      evt.slot_subject = item.new_subject;
      // The head is passed over unless it is strictly later; past the head, the event lands
      // just before the first entry whose time is not less than its own.
      pos = 0;
      if (stored_events.size() > 0 && stored_events[0].slot_time <= evt.slot_time) begin
        pos = stored_events.size();
        for (int i = stored_events.size() - 1; i >= 1; i--) begin
          if (stored_events[i].slot_time >= evt.slot_time) pos = i;
        end
      end
      stored_events.insert(pos, evt);
    end
    res.occupancy = toeq_pkg::OCC_W'(stored_events.size());
    if (stored_events.size() > peak_fill) peak_fill = stored_events.size();
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    toeq_pkg::out_item_t want;
    if (!rst_ni) begin
      stored_events.delete();
      pending_results.delete();
      waiting = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with no expectation, occupancy",
                          32'(out_item_i.occupancy), 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (out_item_i.found !== want.found)
            report_mismatch("found", 32'(out_item_i.found), 32'(want.found));
          if (out_item_i.out_type !== want.out_type)
            report_mismatch("out_type", 32'(out_item_i.out_type), 32'(want.out_type));
          if (out_item_i.out_time !== want.out_time)
            report_mismatch("out_time", out_item_i.out_time, want.out_time);
          if (out_item_i.out_subject !== want.out_subject)
            report_mismatch("out_subject", 32'(out_item_i.out_subject),
                            32'(want.out_subject));
          if (out_item_i.dropped !== want.dropped)
            report_mismatch("dropped", 32'(out_item_i.dropped), 32'(want.dropped));
          if (out_item_i.occupancy !== want.occupancy)
            report_mismatch("occupancy", 32'(out_item_i.occupancy), 32'(want.occupancy));
        end
      end
      if (in_valid_i && in_ready_i) pending_results.push_back(apply_command(in_item_i));
      waiting = pending_results.size();
    end
  end

endmodule

// ===== dv/time_ordered_event_queue_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the time-ordered event queue: clock, reset, command stimulus and verdict.
// Depends on toeq_pkg, time_ordered_event_queue_unit and toeq_scoreboard.
module time_ordered_event_queue_unit_tb;

  // An add may shift up to 63 slots ahead of the head, or up to 62 after a bisection.
  // The watchdog must also sit out the deliberate hold-off of the receiver.
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 120;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int QUIET_FIRST    = 300;
  localparam int QUIET_LAST     = 420;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  toeq_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  toeq_pkg::out_item_t out_item;

  // Shared by the sender, the receiver and the hold-off process; always written with
  // nonblocking assignments so that readers at the same edge see a settled value.
  logic quiet_window = 1'b0;
  logic hold_off     = 1'b0;

  int items_sent   = 0;
  int quiet_cycles = 0;

  int mismatch_count;
  int pending_count;
  int result_count;
  int drop_count;
  int empty_pop_count;
  int peak_occupancy;

  always #6 clk_i = ~clk_i;

  time_ordered_event_queue_unit #(
    .CAPACITY(64)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  toeq_scoreboard #(
    .QUEUE_DEPTH(64)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_item_i       (out_item),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .result_count_o   (result_count),
    .drop_count_o     (drop_count),
    .empty_pop_count_o(empty_pop_count),
    .peak_occupancy_o (peak_occupancy)
  );

  function automatic toeq_pkg::in_item_t make_item(input logic cmd,
                                                   input logic [toeq_pkg::TYPE_W-1:0] kind,
                                                   input logic [toeq_pkg::TIME_W-1:0] at,
                                                   input logic [toeq_pkg::TAG_W-1:0] subj);
    toeq_pkg::in_item_t item;
    item.cmd         = cmd;
    item.new_type    = kind;
    item.new_time    = at;
    item.new_subject = subj;
    return item;
  endfunction

  // Most times come from a handful of values so that equal times, and equal head times in
  // particular, occur often. The rest are fully random or the two extremes.
  function automatic logic [toeq_pkg::TIME_W-1:0] pick_time();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 35) return $urandom();
    else if (sel < 75) return {16'($urandom_range(0, 7)), 16'h0000};
    else if (sel < 90) return toeq_pkg::TIME_W'($urandom_range(0, 31));
    else return $urandom_range(1) ? {toeq_pkg::TIME_W{1'b1}} : '0;
  endfunction

  // Pops carry random payloads too; the block must ignore them.
  function automatic toeq_pkg::in_item_t random_item(input logic cmd);
    return make_item(cmd, toeq_pkg::TYPE_W'($urandom()), pick_time(),
                     toeq_pkg::TAG_W'($urandom()));
  endfunction

  // Offers one item and returns at the edge where the transfer takes place. Valid is only
  // lowered when an idle gap is taken, so back-to-back items keep it high.
  task automatic offer_item(input toeq_pkg::in_item_t item);
    quiet_window <= (items_sent >= QUIET_FIRST && items_sent < QUIET_LAST);
    while (!quiet_window && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Receiver: ready drops in about one cycle in six, never inside the quiet window, and stays
  // low for the whole hold-off.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off) out_ready <= 1'b0;
      else if (quiet_window) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 16);
    end
  end

  // One long hold-off early in the run, while the sender keeps offering items. The result
  // register fills, the sequencer stops, and in_ready stays low until the hold ends.
  initial begin
    do @(posedge clk_i); while (result_count < 60);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Watchdog: ends the run when no transfer happens on either channel for too long.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending_count);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int add_pct;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A pop on an empty queue comes first. Then come adds at the field extremes,
    // an add equal to the head (it must go behind the head) and an add strictly before the head.
    // An add equal to a zero head also must not take the front. A drain then runs two pops past
    // empty.
    offer_item(make_item(toeq_pkg::CMD_POP, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF));
    offer_item(make_item(toeq_pkg::CMD_ADD, 8'h00, 32'h0001_0000, 16'h0000));
    offer_item(make_item(toeq_pkg::CMD_ADD, 8'hFF, 32'h0001_0000, 16'hFFFF));
    offer_item(make_item(toeq_pkg::CMD_ADD, 8'h5A, 32'h0000_0000, 16'h1234));
    offer_item(make_item(toeq_pkg::CMD_ADD, 8'hA5, 32'hFFFF_FFFF, 16'hEDCB));
    offer_item(make_item(toeq_pkg::CMD_ADD, 8'h01, 32'h0001_0000, 16'h0001));
    offer_item(make_item(toeq_pkg::CMD_ADD, 8'h02, 32'h8000_0000, 16'h8000));
    offer_item(make_item(toeq_pkg::CMD_ADD, 8'h03, 32'h0000_0000, 16'h0003));
    offer_item(make_item(toeq_pkg::CMD_ADD, 8'h04, 32'h7FFF_FFFF, 16'h7FFF));
    repeat (10) offer_item(make_item(toeq_pkg::CMD_POP, 8'h00, 32'h0000_0000, 16'h0000));

    // The queue is filled past its capacity, so the last adds are refused, and then drained.
    repeat (70) offer_item(random_item(toeq_pkg::CMD_ADD));
    repeat (70) offer_item(random_item(toeq_pkg::CMD_POP));

    // Segments that lean toward balance, filling or draining, so that the occupancy wanders
    // over its whole range.
    for (int seg = 0; seg < 14; seg++) begin
      case ($urandom_range(2))
        0: add_pct = 50;
        1: add_pct = 75;
        default: add_pct = 25;
      endcase
      repeat (30) offer_item(random_item(($urandom_range(99) < add_pct) ?
                                         toeq_pkg::CMD_ADD : toeq_pkg::CMD_POP));
    end
    in_valid <= 1'b0;

    do @(posedge clk_i); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d commands and %0d results, including %0d adds refused when full",
             items_sent, result_count, drop_count);
    $display("and %0d pops of an empty queue; peak occupancy %0d, one %0d-cycle receiver stall.",
             empty_pop_count, peak_occupancy, HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/toeq_pkg.sv
design/toeq_slot_ram.sv
design/time_ordered_event_queue_unit.sv
design/toeq_checker.sv
dv/toeq_checker.sv
dv/time_ordered_event_queue_unit_tb.sv
